@@ rtl/core/fcrc_pkg.sv @@
// Shared types, constants and the byte-wide CRC step for the framed CRC-16 block.
package fcrc_pkg;

  localparam logic [15:0] CRC_PRESET_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST   = 16'h8408;

  localparam logic REG_PRESET = 1'b0;
  localparam logic REG_POLY   = 1'b1;

  localparam logic FUNC_CHECK    = 1'b0;
  localparam logic FUNC_GENERATE = 1'b1;

  typedef enum logic [1:0] {
    RES_ECHO   = 2'd0,
    RES_CRC_LO = 2'd1,
    RES_CRC_HI = 2'd2
  } res_sel_t;

  // Results caused by one item: the echoed byte alone, or the echo followed
  // by the two CRC bytes when triple is set.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    logic        triple;
    logic        fend;
    logic        ok;
    logic        lerr;
  } grp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ poly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

@@ rtl/core/fcrc_frame.sv @@
// Frame tracking state and CRC datapath; builds the result group for each item.
module fcrc_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               move,
  input  logic               func,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        crc_preset,
  input  logic [15:0]        crc_polynomial,
  output fcrc_pkg::grp_t     grp
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic        mode_r, mode_nxt;
  logic [7:0]  rcl_r, rcl_nxt;
  logic [15:0] crc_new;

  assign crc_new = fcrc_pkg::crc_byte(in_frame_r ? crc_r : crc_preset, data_byte,
                                      crc_polynomial);

  always_comb begin
    crc_nxt      = crc_r;
    left_nxt     = left_r;
    in_frame_nxt = in_frame_r;
    mode_nxt     = mode_r;
    rcl_nxt      = rcl_r;
    grp.data     = data_byte;
    grp.crc      = crc_new;
    grp.triple   = 1'b0;
    grp.fend     = 1'b0;
    grp.ok       = 1'b0;
    grp.lerr     = 1'b0;
    if (!in_frame_r) begin
      if (data_byte < 8'd2) begin
        grp.fend     = 1'b1;
        grp.lerr     = 1'b1;
        in_frame_nxt = 1'b0;
        left_nxt     = 8'd0;
      end else begin
        mode_nxt = func;
        crc_nxt  = crc_new;
        if (func == fcrc_pkg::FUNC_GENERATE && data_byte == 8'd2) begin
          grp.triple   = 1'b1;
          grp.fend     = 1'b1;
          in_frame_nxt = 1'b0;
          left_nxt     = 8'd0;
        end else begin
          in_frame_nxt = 1'b1;
          left_nxt     = (func == fcrc_pkg::FUNC_GENERATE) ? data_byte - 8'd2 : data_byte;
        end
      end
    end else if (mode_r == fcrc_pkg::FUNC_GENERATE) begin
      crc_nxt = crc_new;
      if (left_r > 8'd1) begin
        left_nxt = left_r - 8'd1;
      end else begin
        grp.triple   = 1'b1;
        grp.fend     = 1'b1;
        in_frame_nxt = 1'b0;
        left_nxt     = 8'd0;
      end
    end else begin
      if (left_r > 8'd2) begin
        crc_nxt  = crc_new;
        left_nxt = left_r - 8'd1;
      end else if (left_r == 8'd2) begin
        rcl_nxt  = data_byte;
        left_nxt = 8'd1;
      end else begin
        grp.fend     = 1'b1;
        grp.ok       = (rcl_r == crc_r[7:0]) && (data_byte == crc_r[15:8]);
        in_frame_nxt = 1'b0;
        left_nxt     = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= fcrc_pkg::CRC_PRESET_RST;
      left_r     <= 8'd0;
      in_frame_r <= 1'b0;
      mode_r     <= 1'b0;
      rcl_r      <= 8'd0;
    end else if (move) begin
      crc_r      <= crc_nxt;
      left_r     <= left_nxt;
      in_frame_r <= in_frame_nxt;
      mode_r     <= mode_nxt;
      rcl_r      <= rcl_nxt;
    end
  end

endmodule

@@ rtl/core/fcrc_emit.sv @@
// Holds one result group; hands out its items one per cycle while out_ready is high.
module fcrc_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  fcrc_pkg::grp_t  grp_in,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_is_crc_byte,
  output logic            out_frame_end,
  output logic            out_crc_ok,
  output logic            out_length_error,
  output logic            out_run_last
);

  logic               grp_v_r;
  fcrc_pkg::grp_t     grp_r;
  fcrc_pkg::res_sel_t idx_r;
  logic               last;
  logic               fire;
  logic               done;

  assign last      = !grp_r.triple || idx_r == fcrc_pkg::RES_CRC_HI;
  assign out_valid = grp_v_r;
  assign fire      = grp_v_r && out_ready;
  assign done      = fire && last;
  assign can_load  = !grp_v_r || done;

  always_comb begin
    out_frame_end    = grp_r.fend && last;
    out_crc_ok       = grp_r.ok && last;
    out_length_error = grp_r.lerr;
    out_run_last     = last;
    case (idx_r)
      fcrc_pkg::RES_ECHO: begin
        out_out_byte    = grp_r.data;
        out_is_crc_byte = 1'b0;
      end
      fcrc_pkg::RES_CRC_LO: begin
        out_out_byte    = grp_r.crc[7:0];
        out_is_crc_byte = 1'b1;
      end
      fcrc_pkg::RES_CRC_HI: begin
        out_out_byte    = grp_r.crc[15:8];
        out_is_crc_byte = 1'b1;
      end
      default: begin
        out_out_byte    = grp_r.data;
        out_is_crc_byte = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= fcrc_pkg::RES_ECHO;
    end else if (load) begin
      grp_v_r <= 1'b1;
      idx_r   <= fcrc_pkg::RES_ECHO;
    end else if (done) begin
      grp_v_r <= 1'b0;
    end else if (fire) begin
      idx_r   <= (idx_r == fcrc_pkg::RES_ECHO) ? fcrc_pkg::RES_CRC_LO : fcrc_pkg::RES_CRC_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

  a_crc_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_crc_byte |-> !out_crc_ok && !out_length_error)
    else $error("CRC byte carries a check or length flag");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("Frame end on an item that is not the last of its group");

  a_lerr_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> out_frame_end && !out_is_crc_byte)
    else $error("Length error without a frame end");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r && !grp_r.triple |-> idx_r == fcrc_pkg::RES_ECHO)
    else $error("Single-item group advanced past its echo");

endmodule

@@ rtl/core/framed_crc16_append_check.sv @@
// Top level of the framed CRC-16 appender and checker with its register port.
// The block accepts one byte item per clock cycle while the result register can
// take it. Every byte yields one result item, except the final byte of a
// generate-mode frame (or a generate-mode length byte of two), which yields three:
// the echo, then the CRC low and high bytes, which hold the single result register
// until all are taken before the next group can enter. The CRC of a byte is
// worked out combinationally between the input register and the result register;
// an item passes both, the latter once it is free, before its first result is offered.
// crc_preset is loaded at each length byte; crc_polynomial applies at once.
module framed_crc16_append_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_is_crc_byte,
  output logic        out_frame_end,
  output logic        out_crc_ok,
  output logic        out_length_error,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           in_v_r;
  logic           func_r;
  logic [7:0]     byte_r;
  logic [15:0]    preset_r;
  logic [15:0]    poly_r;
  logic           can_load;
  logic           move;
  logic           reg_wr;
  fcrc_pkg::grp_t grp;

  assign pready   = 1'b1;
  assign reg_wr   = psel && penable && pwrite && pready;
  assign move     = in_v_r && can_load;
  assign in_ready = !in_v_r || move;

  always_comb begin
    case (paddr[2])
      fcrc_pkg::REG_PRESET: prdata = {16'h0000, preset_r};
      fcrc_pkg::REG_POLY:   prdata = {16'h0000, poly_r};
      default:              prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= fcrc_pkg::CRC_PRESET_RST;
      poly_r   <= fcrc_pkg::CRC_POLY_RST;
    end else if (reg_wr) begin
      if (paddr[2] == fcrc_pkg::REG_PRESET) begin
        preset_r <= pwdata[15:0];
      end else begin
        poly_r   <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      byte_r <= in_data_byte;
    end
  end

  fcrc_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .move           (move),
    .func           (func_r),
    .data_byte      (byte_r),
    .crc_preset     (preset_r),
    .crc_polynomial (poly_r),
    .grp            (grp)
  );

  fcrc_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (move),
    .grp_in           (grp),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_is_crc_byte  (out_is_crc_byte),
    .out_frame_end    (out_frame_end),
    .out_crc_ok       (out_crc_ok),
    .out_length_error (out_length_error),
    .out_run_last     (out_run_last)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the framed CRC-16 appender and checker, checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       is_crc;
    logic       fend;
    logic       ok;
    logic       lerr;
    logic       last;
  } frame_res_t;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_CRC_LO,
    FILL_CRC_HI,
    FILL_CRC_BAD
  } fill_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    fill_t      fill;
    logic       typed;
    frame_res_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_is_crc_byte;
  logic        out_frame_end;
  logic        out_crc_ok;
  logic        out_length_error;
  logic        out_run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  frame_res_t  due_results[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_left = 0;

  logic [15:0] cfg_preset = fcrc_pkg::CRC_PRESET_RST;
  logic [15:0] cfg_poly = fcrc_pkg::CRC_POLY_RST;
  logic [15:0] acc_crc = fcrc_pkg::CRC_PRESET_RST;
  logic [7:0]  remaining = 8'd0;
  logic        framing = 1'b0;
  logic        gen_mode = fcrc_pkg::FUNC_CHECK;
  logic [7:0]  rx_crc_lo = 8'd0;

  stim_row_t directed_rows [22] = '{
    '{fcrc_pkg::FUNC_CHECK, 8'h00, FILL_NONE, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{fcrc_pkg::FUNC_GENERATE, 8'h01, FILL_NONE, 1'b1, '{8'h01, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{fcrc_pkg::FUNC_GENERATE, 8'h02, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h02, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h00, FILL_CRC_LO,  1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h00, FILL_CRC_HI,  1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h04, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h00, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'hFF, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h00, FILL_CRC_LO,  1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h00, FILL_CRC_HI,  1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h03, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'hA5, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h00, FILL_CRC_LO,  1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h00, FILL_CRC_BAD, 1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h04, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'hFF, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK,    8'h00, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h03, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_GENERATE, 8'h5A, FILL_NONE,    1'b0, '0},
    '{fcrc_pkg::FUNC_CHECK, 8'h00, FILL_NONE, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{fcrc_pkg::FUNC_GENERATE, 8'h02, FILL_NONE,    1'b0, '0}
  };

  framed_crc16_append_check u_dut (.*);

  always #2 clk = ~clk;

  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ cfg_poly;
      end
    end
    return acc;
  endfunction

  function automatic void close_generate(input logic [7:0] b, ref frame_res_t res[$]);
    res.push_back(frame_res_t'{b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    res.push_back(frame_res_t'{acc_crc[7:0], 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    res.push_back(frame_res_t'{acc_crc[15:8], 1'b1, 1'b1, 1'b0, 1'b0, 1'b1});
    framing = 1'b0;
    remaining = 8'd0;
  endfunction

  function automatic void crc_frame_step(input logic f, input logic [7:0] b,
                                         ref frame_res_t res[$]);
    logic crc_match;
    if (!framing) begin
      if (b < 8'd2) begin
        res.push_back(frame_res_t'{b, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1});
        remaining = 8'd0;
        return;
      end
      gen_mode = f;
      acc_crc = crc16_fold(cfg_preset, b);
      if (gen_mode == fcrc_pkg::FUNC_GENERATE && b == 8'd2) begin
        close_generate(b, res);
        return;
      end
      framing = 1'b1;
      remaining = (gen_mode == fcrc_pkg::FUNC_GENERATE) ? b - 8'd2 : b;
      res.push_back(frame_res_t'{b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    end else if (gen_mode == fcrc_pkg::FUNC_GENERATE) begin
      acc_crc = crc16_fold(acc_crc, b);
      if (remaining > 8'd1) begin
        remaining = remaining - 8'd1;
        res.push_back(frame_res_t'{b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      end else begin
        close_generate(b, res);
      end
    end else if (remaining > 8'd2) begin
      acc_crc = crc16_fold(acc_crc, b);
      remaining = remaining - 8'd1;
      res.push_back(frame_res_t'{b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    end else if (remaining == 8'd2) begin
      rx_crc_lo = b;
      remaining = 8'd1;
      res.push_back(frame_res_t'{b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    end else begin
      crc_match = (rx_crc_lo == acc_crc[7:0]) && (b == acc_crc[15:8]);
      res.push_back(frame_res_t'{b, 1'b0, 1'b1, crc_match, 1'b0, 1'b1});
      framing = 1'b0;
      remaining = 8'd0;
    end
  endfunction

  task automatic send_item(input logic f, input logic [7:0] b, input logic typed,
                           input frame_res_t typed_res);
    frame_res_t produced[$];
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    crc_frame_step(f, b, produced);
    if (typed) begin
      due_results.push_back(typed_res);
    end else begin
      foreach (produced[k]) due_results.push_back(produced[k]);
    end
    items_sent++;
  endtask

  task automatic send_frame(input int forced_len);
    int         kind;
    int         len;
    int         n;
    logic       f;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = (forced_len > 0) ? 99 : $urandom_range(99);
    f = 1'($urandom_range(1));
    len = forced_len;
    if (len <= 0) begin
      len = $urandom_range(12, 2);
    end
    if (kind < 8) begin
      send_item(f, 8'($urandom_range(1)), 1'b0, '0);
    end else if (kind < 14) begin
      send_item(f, 8'($urandom_range(255)), 1'b0, '0);
    end else begin
      // An open frame left by earlier noise is run out first, so that the new
      // length item is seen as one.
      if (kind >= 22) begin
        while (framing) send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, '0);
      end
      send_item(f, 8'(len), 1'b0, '0);
      n = (kind < 22) ? $urandom_range(len - 2) : len - 2;
      repeat (n) send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, '0);
      if (kind >= 22 && f == fcrc_pkg::FUNC_CHECK) begin
        lo = acc_crc[7:0];
        hi = acc_crc[15:8];
        if ($urandom_range(99) < 15) lo = lo ^ 8'(1 << $urandom_range(7));
        if ($urandom_range(99) < 15) hi = hi ^ 8'(1 << $urandom_range(7));
        send_item(1'($urandom_range(1)), lo, 1'b0, '0);
        send_item(1'($urandom_range(1)), hi, 1'b0, '0);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == fcrc_pkg::REG_PRESET) begin
      cfg_preset = value;
    end else begin
      cfg_poly = value;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result item with none awaited: out_byte %h", out_out_byte);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (out_out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_out_byte);
          error_count++;
        end
        if (out_is_crc_byte !== want.is_crc) begin
          $error("is_crc_byte: expected %b, got %b", want.is_crc, out_is_crc_byte);
          error_count++;
        end
        if (out_frame_end !== want.fend) begin
          $error("frame_end: expected %b, got %b", want.fend, out_frame_end);
          error_count++;
        end
        if (out_crc_ok !== want.ok) begin
          $error("crc_ok: expected %b, got %b", want.ok, out_crc_ok);
          error_count++;
        end
        if (out_length_error !== want.lerr) begin
          $error("length_error: expected %b, got %b", want.lerr, out_length_error);
          error_count++;
        end
        if (out_run_last !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, out_run_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0]  b;
    logic [15:0] pre;
    logic [15:0] pol;
    int          p;
    int          target;
    logic        paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 61;
    foreach (directed_rows[i]) begin
      b = directed_rows[i].data;
      case (directed_rows[i].fill)
        FILL_CRC_LO: b = acc_crc[7:0];
        FILL_CRC_HI: b = acc_crc[15:8];
        FILL_CRC_BAD: b = ~acc_crc[15:8];
        default: ;
      endcase
      send_item(directed_rows[i].func, b, directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    for (p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 24 : (p < 4) ? 61 : 0;
      recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 24 : 0;
      if (p > 0) begin
        drain_results();
        case (p)
          1: begin pre = 16'h0000; pol = 16'h0000; end
          2: begin pre = 16'hFFFF; pol = 16'hFFFF; end
          4: begin pre = 16'h0000; pol = fcrc_pkg::CRC_POLY_RST; end
          default: begin pre = 16'($urandom); pol = 16'($urandom); end
        endcase
        write_reg(fcrc_pkg::REG_PRESET, pre);
        write_reg(fcrc_pkg::REG_POLY, pol);
      end
      if (p == 4) begin
        send_frame(255);
      end
      if (p == 5) begin
        stall_left = 300;
      end
      target = items_sent + 20;
      while (items_sent < target) begin
        send_frame(0);
        if (p == 2 && !paused && items_sent > target - 10) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
